// File: sv/bitmap_page_allocator_unit_defines.svh
// Assertion macros for the bitmap page allocator checker.
// Expects clk and rst_n in the scope of use.
`ifndef BITMAP_PAGE_ALLOCATOR_UNIT_DEFINES_SVH
`define BITMAP_PAGE_ALLOCATOR_UNIT_DEFINES_SVH

// same-cycle implication
`define BPA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bitmap page allocator check failed");

// next-cycle implication
`define BPA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bitmap page allocator check failed");

`endif

// File: sv/bpa_pkg.sv
// Shared constants, codes, control types and helper functions of the
// bitmap page allocator. No dependencies.
package bpa_pkg;

    localparam int NUM_PAGES = 65536;
    localparam int WORD_BITS = 64;
    localparam int NUM_WORDS = NUM_PAGES / WORD_BITS;
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int WADDR_W   = $clog2(NUM_WORDS);
    localparam int WCNT_W    = WADDR_W + 1;
    localparam int NBYTES    = WORD_BITS / 8;
    localparam int BCNT_W    = 4;
    localparam int POP_W     = BIT_W + 1;

    localparam int CMD_W   = 3;
    localparam int PAGE_W  = 16;
    localparam int CNT_W   = 17;
    localparam int ZONE_W  = 2;
    localparam int STAT_W  = 2;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [CMD_W-1:0] CMD_ALLOC   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_CONTIG  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_ZONE    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_FREE    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_RESERVE = 3'd4;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 3'd5;

    localparam logic [ZONE_W-1:0] ZSEL_LOW    = 2'd0;
    localparam logic [ZONE_W-1:0] ZSEL_DMA    = 2'd1;
    localparam logic [ZONE_W-1:0] ZSEL_NORMAL = 2'd2;
    localparam logic [ZONE_W-1:0] ZSEL_ANY    = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOMEM   = 2'd1;
    localparam logic [STAT_W-1:0] ST_DFREE   = 2'd2;
    localparam logic [STAT_W-1:0] ST_IGNORED = 2'd3;

    localparam logic [1:0] REG_TOTAL  = 2'd0;
    localparam logic [1:0] REG_LOW    = 2'd1;
    localparam logic [1:0] REG_DMA    = 2'd2;
    localparam logic [1:0] REG_NORMAL = 2'd3;

    localparam logic [CNT_W-1:0] RST_TOTAL  = 17'd65536;
    localparam logic [CNT_W-1:0] RST_LOW    = 17'd256;
    localparam logic [CNT_W-1:0] RST_DMA    = 17'd4096;
    localparam logic [CNT_W-1:0] RST_NORMAL = 17'd65536;

    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_NOP     = 4'd0;
    localparam logic [OP_W-1:0] OP_CLR     = 4'd1;
    localparam logic [OP_W-1:0] OP_LOAD    = 4'd2;
    localparam logic [OP_W-1:0] OP_DISP    = 4'd3;
    localparam logic [OP_W-1:0] OP_READ    = 4'd4;
    localparam logic [OP_W-1:0] OP_CAP     = 4'd5;
    localparam logic [OP_W-1:0] OP_SCAN_EV = 4'd6;
    localparam logic [OP_W-1:0] OP_RUN_EV  = 4'd7;
    localparam logic [OP_W-1:0] OP_FREE_EV = 4'd8;
    localparam logic [OP_W-1:0] OP_RNG_EV  = 4'd9;
    localparam logic [OP_W-1:0] OP_RNG_CNT = 4'd10;
    localparam logic [OP_W-1:0] OP_RNG_ACC = 4'd11;
    localparam logic [OP_W-1:0] OP_EMIT    = 4'd12;

    localparam logic [1:0] K_SCAN = 2'd0;
    localparam logic [1:0] K_RUN  = 2'd1;
    localparam logic [1:0] K_FREE = 2'd2;
    localparam logic [1:0] K_RNG  = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0] op;
    } ctl_cmd_t;

    typedef struct packed {
        logic       clr_last;
        logic       disp_done;
        logic [1:0] disp_kind;
        logic       scan_end;
        logic       run_fail;
        logic       run_found;
        logic       run_next;
        logic       rng_last;
        logic       out_busy;
    } dp_stat_t;

    // bits of the word at base whose page lies in [lo, hi)
    function automatic logic [WORD_BITS-1:0] range_mask(input logic [CNT_W-1:0] base,
                                                        input logic [CNT_W-1:0] lo,
                                                        input logic [CNT_W-1:0] hi);
        logic [CNT_W-1:0]     d_lo;
        logic [CNT_W-1:0]     d_hi;
        logic [WORD_BITS-1:0] m;
        d_lo = (lo > base) ? (lo - base) : '0;
        d_hi = (hi > base) ? (hi - base) : '0;
        if (d_lo >= CNT_W'(WORD_BITS) || hi <= base)
        begin
            m = '0;
        end
        else
        begin
            m = {WORD_BITS{1'b1}} << d_lo[BIT_W-1:0];
            if (d_hi < CNT_W'(WORD_BITS))
            begin
                m = m & ~({WORD_BITS{1'b1}} << d_hi[BIT_W-1:0]);
            end
        end
        return m;
    endfunction

    function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_BITS-1:0] v);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                idx = BIT_W'(i);
            end
        end
        return idx;
    endfunction

    function automatic logic [BCNT_W-1:0] byte_pop(input logic [7:0] v);
        logic [BCNT_W-1:0] n;
        n = '0;
        for (int i = 0; i < 8; i++)
        begin
            n = n + BCNT_W'(v[i]);
        end
        return n;
    endfunction

endpackage

// File: sv/bpa_ifs.sv
// Request and response channel interfaces of the bitmap page allocator.
// Depends on bpa_pkg.
interface bpa_req_if;
    logic                          valid;
    logic                          ready;
    logic [bpa_pkg::CMD_W-1:0]     cmd;
    logic [bpa_pkg::PAGE_W-1:0]    page;
    logic [bpa_pkg::CNT_W-1:0]     count;
    logic [bpa_pkg::ZONE_W-1:0]    zone;

    modport source (output valid, cmd, page, count, zone, input ready);
    modport sink   (input valid, cmd, page, count, zone, output ready);
endinterface

interface bpa_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [bpa_pkg::STAT_W-1:0]    status;
    logic [bpa_pkg::PAGE_W-1:0]    alloc_page;
    logic [bpa_pkg::CNT_W-1:0]     free_pages;
    logic [bpa_pkg::CNT_W-1:0]     used_pages;

    modport source (output valid, status, alloc_page, free_pages, used_pages, input ready);
    modport sink   (input valid, status, alloc_page, free_pages, used_pages, output ready);
endinterface

// File: sv/bpa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bpa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/bpa_ctl.sv
// Controller state machine of the bitmap page allocator.
// Depends on bpa_pkg; drives bpa_dp through ctl_cmd_t, reads dp_stat_t.
module bpa_ctl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  bpa_pkg::dp_stat_t stat,
    output bpa_pkg::ctl_cmd_t ctl
);

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_DISP = 4'd2;
    localparam logic [3:0] S_READ = 4'd3;
    localparam logic [3:0] S_CAP  = 4'd4;
    localparam logic [3:0] S_SCAN = 4'd5;
    localparam logic [3:0] S_RUN  = 4'd6;
    localparam logic [3:0] S_FREE = 4'd7;
    localparam logic [3:0] S_RNG  = 4'd8;
    localparam logic [3:0] S_CNT  = 4'd9;
    localparam logic [3:0] S_ACC  = 4'd10;
    localparam logic [3:0] S_DONE = 4'd11;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic [1:0] kind_reg;
    logic [1:0] kind_next;

    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        ctl.op     = bpa_pkg::OP_NOP;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_CLR:
            begin
                ctl.op = bpa_pkg::OP_CLR;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.op     = bpa_pkg::OP_LOAD;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                ctl.op = bpa_pkg::OP_DISP;
                if (stat.disp_done)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    kind_next  = stat.disp_kind;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                ctl.op     = bpa_pkg::OP_READ;
                state_next = S_CAP;
            end
            S_CAP:
            begin
                ctl.op = bpa_pkg::OP_CAP;
                unique case (kind_reg)
                    bpa_pkg::K_SCAN: state_next = S_SCAN;
                    bpa_pkg::K_RUN:  state_next = S_RUN;
                    bpa_pkg::K_FREE: state_next = S_FREE;
                    bpa_pkg::K_RNG:  state_next = S_RNG;
                    default:         state_next = S_IDLE;
                endcase
            end
            S_SCAN:
            begin
                ctl.op     = bpa_pkg::OP_SCAN_EV;
                state_next = stat.scan_end ? S_DONE : S_READ;
            end
            S_RUN:
            begin
                ctl.op = bpa_pkg::OP_RUN_EV;
                if (stat.run_fail)
                begin
                    state_next = S_DONE;
                end
                else if (stat.run_found)
                begin
                    kind_next  = bpa_pkg::K_RNG;
                    state_next = S_READ;
                end
                else if (stat.run_next)
                begin
                    state_next = S_READ;
                end
            end
            S_FREE:
            begin
                ctl.op     = bpa_pkg::OP_FREE_EV;
                state_next = S_DONE;
            end
            S_RNG:
            begin
                ctl.op     = bpa_pkg::OP_RNG_EV;
                state_next = S_CNT;
            end
            S_CNT:
            begin
                ctl.op     = bpa_pkg::OP_RNG_CNT;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                ctl.op     = bpa_pkg::OP_RNG_ACC;
                state_next = stat.rng_last ? S_DONE : S_READ;
            end
            S_DONE:
            begin
                if (!stat.out_busy)
                begin
                    ctl.op     = bpa_pkg::OP_EMIT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            kind_reg  <= bpa_pkg::K_SCAN;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

endmodule

// File: sv/bpa_dp.sv
// Datapath of the bitmap page allocator: bitmap RAM, counters, scan
// pointers, configuration registers and result register.
// Depends on bpa_pkg and bpa_ram; steered by bpa_ctl.
module bpa_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bpa_pkg::ctl_cmd_t             ctl,
    output bpa_pkg::dp_stat_t             stat,
    input  logic [bpa_pkg::CMD_W-1:0]     req_cmd,
    input  logic [bpa_pkg::PAGE_W-1:0]    req_page,
    input  logic [bpa_pkg::CNT_W-1:0]     req_count,
    input  logic [bpa_pkg::ZONE_W-1:0]    req_zone,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output logic [bpa_pkg::STAT_W-1:0]    rsp_status,
    output logic [bpa_pkg::PAGE_W-1:0]    rsp_alloc_page,
    output logic [bpa_pkg::CNT_W-1:0]     rsp_free_pages,
    output logic [bpa_pkg::CNT_W-1:0]     rsp_used_pages,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bpa_pkg::PADDR_W-1:0]   paddr,
    input  logic [bpa_pkg::PDATA_W-1:0]   pwdata,
    output logic [bpa_pkg::PDATA_W-1:0]   prdata
);

    localparam int WB  = bpa_pkg::WORD_BITS;
    localparam int BW  = bpa_pkg::BIT_W;
    localparam int AW  = bpa_pkg::WADDR_W;
    localparam int NW  = bpa_pkg::WCNT_W;
    localparam int CW  = bpa_pkg::CNT_W;
    localparam int PW  = bpa_pkg::PAGE_W;
    localparam int SW  = bpa_pkg::STAT_W;

    // configuration
    logic [CW-1:0] total_reg, total_next;
    logic [CW-1:0] zlow_reg, zlow_next;
    logic [CW-1:0] zdma_reg, zdma_next;
    logic [CW-1:0] znorm_reg, znorm_next;

    // item
    logic [bpa_pkg::CMD_W-1:0]  cmd_reg, cmd_next;
    logic [PW-1:0]              page_reg, page_next;
    logic [CW-1:0]              count_reg, count_next;
    logic [bpa_pkg::ZONE_W-1:0] zone_reg, zone_next;

    // allocator state
    logic [CW-1:0] free_reg, free_next;
    logic [PW-1:0] hint_reg, hint_next;

    // walk
    logic [AW-1:0] wptr_reg, wptr_next;
    logic [NW-1:0] remain_reg, remain_next;
    logic [CW-1:0] lo_reg, lo_next;
    logic [CW-1:0] hi_reg, hi_next;
    logic          nf_reg, nf_next;
    logic          set_reg, set_next;
    logic [CW-1:0] pptr_reg, pptr_next;
    logic [CW-1:0] run_reg, run_next;
    logic [PW-1:0] first_reg, first_next;
    logic [WB-1:0] word_reg, word_next;
    logic [WB-1:0] chg_reg, chg_next;
    logic [bpa_pkg::NBYTES-1:0][bpa_pkg::BCNT_W-1:0] bcnt_reg, bcnt_next;

    // result
    logic [SW-1:0] status_reg, status_next;
    logic [PW-1:0] got_reg, got_next;
    logic          ovalid_reg, ovalid_next;
    logic [SW-1:0] ostat_reg, ostat_next;
    logic [PW-1:0] opage_reg, opage_next;
    logic [CW-1:0] ofree_reg, ofree_next;
    logic [CW-1:0] oused_reg, oused_next;

    // RAM
    logic          ram_we;
    logic          ram_re;
    logic [WB-1:0] ram_wdata;
    logic [WB-1:0] ram_rdata;

    // derived
    logic [CW-1:0] tot;
    logic [CW-1:0] tot_rnd;
    logic [NW-1:0] words;
    logic [CW-1:0] zsel;
    logic [CW-1:0] zlim;
    logic [CW-1:0] zlim_rnd;
    logic [NW-1:0] zwords;
    logic [NW-1:0] sw;
    logic [AW-1:0] start;
    logic          is_next;
    logic [CW-1:0] page_ext;
    logic [CW-1:0] rend_sum;
    logic [CW-1:0] rend;
    logic          d_done;
    logic [1:0]    d_kind;
    logic [SW-1:0] d_status;
    logic [CW-1:0] base;
    logic [WB-1:0] wmask;
    logic [WB-1:0] cand;
    logic          found;
    logic [BW-1:0] fbit;
    logic [CW-1:0] fpage;
    logic [CW-1:0] fpage1;
    logic [AW-1:0] wnext;
    logic [BW-1:0] roff;
    logic          r_fail;
    logic          r_skip;
    logic          r_used;
    logic [CW-1:0] r_inc;
    logic          r_hit;
    logic [PW-1:0] rlo;
    logic          r_found;
    logic          r_next;
    logic [BW-1:0] foff;
    logic          fused;
    logic [WB-1:0] rchg;
    logic [WB-1:0] rnew;
    logic [bpa_pkg::POP_W-1:0] popsum;
    logic [CW-1:0] hm1;
    logic          rlast;
    logic          cfg_wr;
    logic [1:0]    cfg_idx;
    logic          emit;

    bpa_ram #(
        .WIDTH (WB),
        .DEPTH (bpa_pkg::NUM_WORDS)
    ) u_bitmap (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wptr_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (wptr_reg),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        tot      = (total_reg > CW'(bpa_pkg::NUM_PAGES)) ? CW'(bpa_pkg::NUM_PAGES) : total_reg;
        tot_rnd  = tot + CW'(WB - 1);
        words    = tot_rnd[BW +: NW];
        case (zone_reg)
            bpa_pkg::ZSEL_LOW: zsel = zlow_reg;
            bpa_pkg::ZSEL_DMA: zsel = zdma_reg;
            default:           zsel = znorm_reg;
        endcase
        zlim     = (zsel > tot) ? tot : zsel;
        zlim_rnd = zlim + CW'(WB - 1);
        zwords   = zlim_rnd[BW +: NW];
        sw       = NW'(hint_reg >> BW);
        start    = (sw >= words) ? '0 : sw[AW-1:0];
        is_next  = (cmd_reg == bpa_pkg::CMD_ALLOC)
                || (cmd_reg == bpa_pkg::CMD_ZONE && zone_reg == bpa_pkg::ZSEL_ANY)
                || (cmd_reg == bpa_pkg::CMD_CONTIG && count_reg == CW'(1));
        page_ext = CW'(page_reg);
        rend_sum = page_ext + count_reg;
        rend     = (rend_sum > tot) ? tot : rend_sum;

        // word walk
        base   = CW'({wptr_reg, {BW{1'b0}}});
        wmask  = bpa_pkg::range_mask(base, lo_reg, hi_reg);
        cand   = ~word_reg & wmask;
        found  = |cand;
        fbit   = bpa_pkg::lowest_set(cand);
        fpage  = base + CW'(fbit);
        fpage1 = fpage + CW'(1);
        wnext  = (NW'(wptr_reg) + NW'(1) == words) ? '0 : wptr_reg + AW'(1);

        // contiguous run, one page a cycle within a captured word
        roff    = pptr_reg[BW-1:0];
        r_fail  = pptr_reg >= tot;
        r_skip  = (roff == '0) && (&word_reg);
        r_used  = word_reg[roff];
        r_inc   = run_reg + CW'(1);
        r_hit   = !r_used && (r_inc == count_reg);
        rlo     = (run_reg == '0) ? pptr_reg[PW-1:0] : first_reg;
        r_found = !r_fail && !r_skip && r_hit;
        r_next  = !r_fail && !r_found && (r_skip || (&roff));

        foff  = page_reg[BW-1:0];
        fused = word_reg[foff];

        rchg = set_reg ? (wmask & ~word_reg) : (wmask & word_reg);
        rnew = set_reg ? (word_reg | wmask) : (word_reg & ~wmask);

        popsum = '0;
        for (int i = 0; i < bpa_pkg::NBYTES; i++)
        begin
            popsum = popsum + bpa_pkg::POP_W'(bcnt_reg[i]);
        end
        hm1   = hi_reg - CW'(1);
        rlast = (wptr_reg == hm1[BW +: AW]);

        // dispatch
        d_done   = 1'b0;
        d_kind   = bpa_pkg::K_SCAN;
        d_status = bpa_pkg::ST_OK;
        if (is_next)
        begin
            if (free_reg == '0 || words == '0)
            begin
                d_done   = 1'b1;
                d_status = bpa_pkg::ST_NOMEM;
            end
        end
        else
        begin
            unique case (cmd_reg) inside
                bpa_pkg::CMD_CONTIG:
                begin
                    d_kind = bpa_pkg::K_RUN;
                    if (count_reg == '0 || count_reg > free_reg)
                    begin
                        d_done   = 1'b1;
                        d_status = bpa_pkg::ST_NOMEM;
                    end
                end
                bpa_pkg::CMD_ZONE:
                begin
                    if (zwords == '0)
                    begin
                        d_done   = 1'b1;
                        d_status = bpa_pkg::ST_NOMEM;
                    end
                end
                bpa_pkg::CMD_FREE:
                begin
                    d_kind = bpa_pkg::K_FREE;
                    if (page_reg == '0 || page_ext >= tot)
                    begin
                        d_done   = 1'b1;
                        d_status = bpa_pkg::ST_IGNORED;
                    end
                end
                bpa_pkg::CMD_RESERVE, bpa_pkg::CMD_RELEASE:
                begin
                    d_kind = bpa_pkg::K_RNG;
                    if (page_ext >= rend)
                    begin
                        d_done = 1'b1;
                    end
                end
                default:
                begin
                    d_done   = 1'b1;
                    d_status = bpa_pkg::ST_IGNORED;
                end
            endcase
        end

        cfg_wr  = psel && penable && pwrite;
        cfg_idx = paddr[3:2];
        emit    = (ctl.op == bpa_pkg::OP_EMIT);
    end

    always_comb
    begin
        unique case (cfg_idx)
            bpa_pkg::REG_TOTAL: prdata = bpa_pkg::PDATA_W'(total_reg);
            bpa_pkg::REG_LOW:   prdata = bpa_pkg::PDATA_W'(zlow_reg);
            bpa_pkg::REG_DMA:   prdata = bpa_pkg::PDATA_W'(zdma_reg);
            default:            prdata = bpa_pkg::PDATA_W'(znorm_reg);
        endcase
    end

    always_comb
    begin
        total_next  = total_reg;
        zlow_next   = zlow_reg;
        zdma_next   = zdma_reg;
        znorm_next  = znorm_reg;
        cmd_next    = cmd_reg;
        page_next   = page_reg;
        count_next  = count_reg;
        zone_next   = zone_reg;
        free_next   = free_reg;
        hint_next   = hint_reg;
        wptr_next   = wptr_reg;
        remain_next = remain_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        nf_next     = nf_reg;
        set_next    = set_reg;
        pptr_next   = pptr_reg;
        run_next    = run_reg;
        first_next  = first_reg;
        word_next   = word_reg;
        chg_next    = chg_reg;
        bcnt_next   = bcnt_reg;
        status_next = status_reg;
        got_next    = got_reg;
        ostat_next  = ostat_reg;
        opage_next  = opage_reg;
        ofree_next  = ofree_reg;
        oused_next  = oused_reg;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_wdata   = word_reg;

        if (cfg_wr)
        begin
            unique case (cfg_idx)
                bpa_pkg::REG_TOTAL: total_next = pwdata[CW-1:0];
                bpa_pkg::REG_LOW:   zlow_next  = pwdata[CW-1:0];
                bpa_pkg::REG_DMA:   zdma_next  = pwdata[CW-1:0];
                default:            znorm_next = pwdata[CW-1:0];
            endcase
        end

        unique case (ctl.op)
            bpa_pkg::OP_CLR:
            begin
                ram_we    = 1'b1;
                ram_wdata = {WB{1'b1}};
                wptr_next = wptr_reg + AW'(1);
            end
            bpa_pkg::OP_LOAD:
            begin
                cmd_next   = req_cmd;
                page_next  = req_page;
                count_next = req_count;
                zone_next  = req_zone;
            end
            bpa_pkg::OP_DISP:
            begin
                status_next = d_status;
                got_next    = '0;
                if (is_next)
                begin
                    wptr_next   = start;
                    remain_next = words;
                    lo_next     = '0;
                    hi_next     = tot;
                    nf_next     = 1'b1;
                end
                else if (cmd_reg == bpa_pkg::CMD_ZONE)
                begin
                    wptr_next   = '0;
                    remain_next = zwords;
                    lo_next     = CW'(1);
                    hi_next     = zlim;
                    nf_next     = 1'b0;
                end
                else if (cmd_reg == bpa_pkg::CMD_CONTIG)
                begin
                    wptr_next = '0;
                    pptr_next = CW'(1);
                    run_next  = '0;
                end
                else
                begin
                    wptr_next = page_reg[BW +: AW];
                    lo_next   = page_ext;
                    hi_next   = rend;
                    set_next  = (cmd_reg == bpa_pkg::CMD_RESERVE);
                end
            end
            bpa_pkg::OP_READ:
            begin
                ram_re = 1'b1;
            end
            bpa_pkg::OP_CAP:
            begin
                word_next = ram_rdata;
            end
            bpa_pkg::OP_SCAN_EV:
            begin
                if (found)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = word_reg | ({{(WB-1){1'b0}}, 1'b1} << fbit);
                    free_next = free_reg - CW'(1);
                    got_next  = fpage[PW-1:0];
                    if (nf_reg)
                    begin
                        hint_next = (fpage1 >= tot) ? '0 : fpage1[PW-1:0];
                    end
                end
                else
                begin
                    remain_next = remain_reg - NW'(1);
                    wptr_next   = wnext;
                    if (remain_reg == NW'(1))
                    begin
                        status_next = bpa_pkg::ST_NOMEM;
                    end
                end
            end
            bpa_pkg::OP_RUN_EV:
            begin
                if (r_fail)
                begin
                    status_next = bpa_pkg::ST_NOMEM;
                end
                else if (r_skip)
                begin
                    run_next  = '0;
                    pptr_next = pptr_reg + CW'(WB);
                    wptr_next = wptr_reg + AW'(1);
                end
                else if (r_found)
                begin
                    lo_next   = CW'(rlo);
                    hi_next   = CW'(rlo) + count_reg;
                    wptr_next = rlo[BW +: AW];
                    got_next  = rlo;
                    set_next  = 1'b1;
                end
                else
                begin
                    if (r_used)
                    begin
                        run_next = '0;
                    end
                    else
                    begin
                        run_next   = r_inc;
                        first_next = rlo;
                    end
                    pptr_next = pptr_reg + CW'(1);
                    if (&roff)
                    begin
                        wptr_next = wptr_reg + AW'(1);
                    end
                end
            end
            bpa_pkg::OP_FREE_EV:
            begin
                if (!fused)
                begin
                    status_next = bpa_pkg::ST_DFREE;
                end
                else
                begin
                    ram_we    = 1'b1;
                    ram_wdata = word_reg & ~({{(WB-1){1'b0}}, 1'b1} << foff);
                    free_next = free_reg + CW'(1);
                    if (page_reg < hint_reg)
                    begin
                        hint_next = page_reg;
                    end
                end
            end
            bpa_pkg::OP_RNG_EV:
            begin
                ram_we    = 1'b1;
                ram_wdata = rnew;
                chg_next  = rchg;
            end
            bpa_pkg::OP_RNG_CNT:
            begin
                for (int i = 0; i < bpa_pkg::NBYTES; i++)
                begin
                    bcnt_next[i] = bpa_pkg::byte_pop(chg_reg[8*i +: 8]);
                end
            end
            bpa_pkg::OP_RNG_ACC:
            begin
                free_next = set_reg ? (free_reg - CW'(popsum)) : (free_reg + CW'(popsum));
                if (!rlast)
                begin
                    wptr_next = wptr_reg + AW'(1);
                end
            end
            bpa_pkg::OP_EMIT:
            begin
                ostat_next = status_reg;
                opage_next = (status_reg == bpa_pkg::ST_OK) ? got_reg : '0;
                ofree_next = free_reg;
                oused_next = (tot > free_reg) ? (tot - free_reg) : '0;
            end
            default:
            begin
            end
        endcase

        if (emit)
        begin
            ovalid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            ovalid_next = 1'b0;
        end
        else
        begin
            ovalid_next = ovalid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg  <= bpa_pkg::RST_TOTAL;
            zlow_reg   <= bpa_pkg::RST_LOW;
            zdma_reg   <= bpa_pkg::RST_DMA;
            znorm_reg  <= bpa_pkg::RST_NORMAL;
            free_reg   <= '0;
            hint_reg   <= '0;
            wptr_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            total_reg  <= total_next;
            zlow_reg   <= zlow_next;
            zdma_reg   <= zdma_next;
            znorm_reg  <= znorm_next;
            free_reg   <= free_next;
            hint_reg   <= hint_next;
            wptr_reg   <= wptr_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        page_reg   <= page_next;
        count_reg  <= count_next;
        zone_reg   <= zone_next;
        remain_reg <= remain_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        nf_reg     <= nf_next;
        set_reg    <= set_next;
        pptr_reg   <= pptr_next;
        run_reg    <= run_next;
        first_reg  <= first_next;
        word_reg   <= word_next;
        chg_reg    <= chg_next;
        bcnt_reg   <= bcnt_next;
        status_reg <= status_next;
        got_reg    <= got_next;
        ostat_reg  <= ostat_next;
        opage_reg  <= opage_next;
        ofree_reg  <= ofree_next;
        oused_reg  <= oused_next;
    end

    always_comb
    begin
        stat.clr_last  = (wptr_reg == AW'(bpa_pkg::NUM_WORDS - 1));
        stat.disp_done = d_done;
        stat.disp_kind = d_kind;
        stat.scan_end  = found || (remain_reg == NW'(1));
        stat.run_fail  = r_fail;
        stat.run_found = r_found;
        stat.run_next  = r_next;
        stat.rng_last  = rlast;
        stat.out_busy  = ovalid_reg && !rsp_ready;
    end

    assign rsp_valid      = ovalid_reg;
    assign rsp_status     = ostat_reg;
    assign rsp_alloc_page = opage_reg;
    assign rsp_free_pages = ofree_reg;
    assign rsp_used_pages = oused_reg;

endmodule

// File: sv/bitmap_page_allocator_unit.sv
// Bitmap page allocator: takes and dispatches a word, then scans bitmap words (read,
// capture, test), or reads, captures, writes, counts and sums each word of a reserved or
// released range; a contiguous search tests one page per cycle within each word it reads
// (skipping a fully used word). One word in flight; emitting into the free result register
// frees the input. After rst_n the bitmap RAM is set to all ones; no request is taken then.
// Depends on bpa_pkg, bpa_ifs, bpa_ctl, bpa_dp.
module bitmap_page_allocator_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    bpa_req_if.sink                       req,
    bpa_rsp_if.source                     rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bpa_pkg::PADDR_W-1:0]   paddr,
    input  logic [bpa_pkg::PDATA_W-1:0]   pwdata,
    output logic [bpa_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    bpa_pkg::ctl_cmd_t ctl;
    bpa_pkg::dp_stat_t stat;

    assign pready = 1'b1;

    bpa_ctl u_ctl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .stat     (stat),
        .ctl      (ctl)
    );

    bpa_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl            (ctl),
        .stat           (stat),
        .req_cmd        (req.cmd),
        .req_page       (req.page),
        .req_count      (req.count),
        .req_zone       (req.zone),
        .rsp_valid      (rsp.valid),
        .rsp_ready      (rsp.ready),
        .rsp_status     (rsp.status),
        .rsp_alloc_page (rsp.alloc_page),
        .rsp_free_pages (rsp.free_pages),
        .rsp_used_pages (rsp.used_pages),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata)
    );

endmodule

// File: sv/bpa_checker.sv
// Port-level checks of the bitmap page allocator, bound to the top level.
// Depends on bpa_pkg and bitmap_page_allocator_unit_defines.svh.
`include "bitmap_page_allocator_unit_defines.svh"

module bpa_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          req_valid,
    input logic                          req_ready,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic [bpa_pkg::STAT_W-1:0]    rsp_status,
    input logic [bpa_pkg::PAGE_W-1:0]    rsp_alloc_page,
    input logic [bpa_pkg::CNT_W-1:0]     rsp_free_pages,
    input logic [bpa_pkg::CNT_W-1:0]     rsp_used_pages
);

    // hold the response word while stalled
    `BPA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_alloc_page) && $stable(rsp_free_pages) && $stable(rsp_used_pages))

    // one request word at a time
    `BPA_ASSERT_NEXT(a_busy_after_take, req_valid && req_ready, !req_ready)

    // failed or ignored commands return page zero
    `BPA_ASSERT_NOW(a_zero_page_on_error, rsp_valid && rsp_status != bpa_pkg::ST_OK, rsp_alloc_page == '0)

endmodule

bind bitmap_page_allocator_unit bpa_checker u_bpa_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_status     (rsp.status),
    .rsp_alloc_page (rsp.alloc_page),
    .rsp_free_pages (rsp.free_pages),
    .rsp_used_pages (rsp.used_pages)
);

// File: bench/bpa_alloc_scoreboard.sv
// Page allocation scoreboard: keeps its own copy of the page bitmap and counters,
// works out the expected word for every accepted request and checks each response.
// Depends on bpa_pkg.
`timescale 1ns / 100ps

class bpa_alloc_scoreboard;

    typedef struct packed {
        logic [bpa_pkg::STAT_W-1:0] status;
        logic [bpa_pkg::PAGE_W-1:0] alloc_page;
        logic [bpa_pkg::CNT_W-1:0]  free_pages;
        logic [bpa_pkg::CNT_W-1:0]  used_pages;
    } rsp_word_t;

    bit        used_map [bpa_pkg::NUM_PAGES];
    int        free_cnt;
    int        hint;
    int        total_reg;
    int        low_lim;
    int        dma_lim;
    int        normal_lim;
    rsp_word_t pending [$];
    int        mismatches;
    int        checked;

    function new();
        foreach (used_map[i])
        begin
            used_map[i] = 1'b1;
        end
        free_cnt   = 0;
        hint       = 0;
        total_reg  = bpa_pkg::RST_TOTAL;
        low_lim    = bpa_pkg::RST_LOW;
        dma_lim    = bpa_pkg::RST_DMA;
        normal_lim = bpa_pkg::RST_NORMAL;
        mismatches = 0;
        checked    = 0;
    endfunction

    function int pages_now();
        return (total_reg < bpa_pkg::NUM_PAGES) ? total_reg : bpa_pkg::NUM_PAGES;
    endfunction

    function void set_reg(logic [1:0] idx, logic [bpa_pkg::CNT_W-1:0] v);
        case (idx)
            bpa_pkg::REG_TOTAL:  total_reg  = v;
            bpa_pkg::REG_LOW:    low_lim    = v;
            bpa_pkg::REG_DMA:    dma_lim    = v;
            bpa_pkg::REG_NORMAL: normal_lim = v;
        endcase
    endfunction

    function void take(int p);
        used_map[p] = 1'b1;
        free_cnt--;
    endfunction

    function void give(int p);
        used_map[p] = 1'b0;
        free_cnt++;
    endfunction

    function bit next_fit(output int pg);
        int tot;
        int words;
        int sw;
        int lo;
        int hi;
        int b;
        int p;
        tot   = pages_now();
        words = (tot + bpa_pkg::WORD_BITS - 1) / bpa_pkg::WORD_BITS;
        sw    = hint / bpa_pkg::WORD_BITS;
        pg    = 0;
        if (free_cnt == 0)
        begin
            return 1'b0;
        end
        if (sw > words)
        begin
            sw = words;
        end
        for (int pass = 0; pass < 2; pass++)
        begin
            lo = pass ? 0 : sw;
            hi = pass ? sw : words;
            for (int w = lo; w < hi; w++)
            begin
                b = -1;
                for (int i = 0; i < bpa_pkg::WORD_BITS; i++)
                begin
                    if (b < 0 && !used_map[w * bpa_pkg::WORD_BITS + i])
                    begin
                        b = i;
                    end
                end
                if (b < 0)
                begin
                    continue;
                end
                p = w * bpa_pkg::WORD_BITS + b;
                if (p >= tot)
                begin
                    continue;
                end
                take(p);
                hint = (p + 1 >= tot) ? 0 : p + 1;
                pg = p;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function bit zone_fit(int limit, output int pg);
        int tot;
        tot = pages_now();
        pg  = 0;
        if (limit > tot)
        begin
            limit = tot;
        end
        for (int p = 1; p < limit; p++)
        begin
            if (!used_map[p])
            begin
                take(p);
                pg = p;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function bit run_fit(int n, output int pg);
        int tot;
        int run;
        int first;
        tot   = pages_now();
        run   = 0;
        first = 0;
        pg    = 0;
        if (n == 0)
        begin
            return 1'b0;
        end
        if (n == 1)
        begin
            return next_fit(pg);
        end
        if (free_cnt < n)
        begin
            return 1'b0;
        end
        for (int p = 1; p < tot; p++)
        begin
            if (used_map[p])
            begin
                run = 0;
                continue;
            end
            if (run == 0)
            begin
                first = p;
            end
            run++;
            if (run == n)
            begin
                for (int q = first; q < first + n; q++)
                begin
                    take(q);
                end
                pg = first;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function void note_req(logic [2:0] cmd, int page, int count, logic [1:0] zone);
        rsp_word_t e;
        int        tot;
        int        got;
        int        used;
        bit        ok;
        tot = pages_now();
        got = 0;
        e.status = bpa_pkg::ST_OK;
        case (cmd)
            bpa_pkg::CMD_ALLOC:
            begin
                ok = next_fit(got);
                e.status = ok ? bpa_pkg::ST_OK : bpa_pkg::ST_NOMEM;
            end
            bpa_pkg::CMD_CONTIG:
            begin
                ok = run_fit(count, got);
                e.status = ok ? bpa_pkg::ST_OK : bpa_pkg::ST_NOMEM;
            end
            bpa_pkg::CMD_ZONE:
            begin
                case (zone)
                    bpa_pkg::ZSEL_LOW:    ok = zone_fit(low_lim, got);
                    bpa_pkg::ZSEL_DMA:    ok = zone_fit(dma_lim, got);
                    bpa_pkg::ZSEL_NORMAL: ok = zone_fit(normal_lim, got);
                    default:              ok = next_fit(got);
                endcase
                e.status = ok ? bpa_pkg::ST_OK : bpa_pkg::ST_NOMEM;
            end
            bpa_pkg::CMD_FREE:
            begin
                if (page == 0 || page >= tot)
                begin
                    e.status = bpa_pkg::ST_IGNORED;
                end
                else if (!used_map[page])
                begin
                    e.status = bpa_pkg::ST_DFREE;
                end
                else
                begin
                    give(page);
                    if (page < hint)
                    begin
                        hint = page;
                    end
                end
            end
            bpa_pkg::CMD_RESERVE:
            begin
                for (int p = page; p < page + count && p < tot; p++)
                begin
                    if (!used_map[p])
                    begin
                        take(p);
                    end
                end
            end
            bpa_pkg::CMD_RELEASE:
            begin
                for (int p = page; p < page + count && p < tot; p++)
                begin
                    if (used_map[p])
                    begin
                        give(p);
                    end
                end
            end
            default:
            begin
                e.status = bpa_pkg::ST_IGNORED;
            end
        endcase
        if (e.status != bpa_pkg::ST_OK)
        begin
            got = 0;
        end
        used = (tot > free_cnt) ? tot - free_cnt : 0;
        e.alloc_page = got[15:0];
        e.free_pages = (free_cnt > 'h1FFFF) ? 17'h1FFFF : free_cnt[16:0];
        e.used_pages = (used > 'h1FFFF) ? 17'h1FFFF : used[16:0];
        pending.push_back(e);
    endfunction

    function void check_rsp(rsp_word_t got);
        rsp_word_t e;
        checked++;
        if (pending.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("unexpected response word: st=%0d pg=%0d free=%0d used=%0d",
                         got.status, got.alloc_page, got.free_pages, got.used_pages);
            end
            return;
        end
        e = pending.pop_front();
        if (got !== e)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("mismatch at word %0d: expected st=%0d pg=%0d free=%0d used=%0d",
                         checked, e.status, e.alloc_page, e.free_pages, e.used_pages);
                $display("                     actual   st=%0d pg=%0d free=%0d used=%0d",
                         got.status, got.alloc_page, got.free_pages, got.used_pages);
            end
        end
    endfunction

endclass

// File: bench/testbench.sv
// Top level of the page allocator bench: clock, reset, APB register writes,
// request and response drivers with random idling, watchdog. Depends on bpa_pkg,
// bpa_ifs, bpa_alloc_scoreboard and the bitmap_page_allocator_unit RTL.
`timescale 1ns / 100ps

module testbench;

    localparam int WATCHDOG_LIMIT = 300000;
    localparam logic [bpa_pkg::CMD_W-1:0] CMD_UNDEF_LO = 3'd6;
    localparam logic [bpa_pkg::CMD_W-1:0] CMD_UNDEF_HI = 3'd7;

    logic                        clk;
    logic                        rst_n;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [bpa_pkg::PADDR_W-1:0] paddr;
    logic [bpa_pkg::PDATA_W-1:0] pwdata;
    logic [bpa_pkg::PDATA_W-1:0] prdata;
    logic                        pready;

    bpa_req_if req ();
    bpa_rsp_if rsp ();

    bitmap_page_allocator_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rsp     (rsp),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    bpa_alloc_scoreboard sb;
    bit  idle_on;
    bit  hold_req;
    int  sent;
    int  quiet = 0;
    int  n_phases;

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // note accepted requests, check accepted responses
    always @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            sb.note_req(req.cmd, req.page, req.count, req.zone);
        end
        if (rsp.valid && rsp.ready)
        begin
            sb.check_rsp({rsp.status, rsp.alloc_page, rsp.free_pages, rsp.used_pages});
        end
    end

    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || psel)
        begin
            quiet <= 0;
        end
        else
        begin
            quiet <= quiet + 1;
        end
        if (quiet >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired with %0d words outstanding", sb.pending.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // response side: random hold-offs, one long stall on request
    initial
    begin
        int gap;
        bit stalled;
        stalled   = 1'b0;
        rsp.ready = 1'b0;
        @(posedge clk);
        forever
        begin
            gap = idle_on ? $urandom_range(0, 16) : 0;
            if (hold_req && !stalled)
            begin
                gap     = 400;
                stalled = 1'b1;
            end
            if (gap > 0)
            begin
                rsp.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp.ready <= 1'b1;
            do @(posedge clk); while (!rsp.valid);
        end
    end

    task automatic reg_write(logic [1:0] idx, logic [bpa_pkg::CNT_W-1:0] v);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= bpa_pkg::PDATA_W'(v);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(idx, v);
    endtask

    // expects to be called at a rising edge
    task automatic send(logic [2:0] cmd, int page, int count, logic [1:0] zone);
        int gap;
        gap = idle_on ? $urandom_range(0, 16) : 0;
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid <= 1'b1;
        req.cmd   <= cmd;
        req.page  <= page[15:0];
        req.count <= count[16:0];
        req.zone  <= zone;
        do @(posedge clk); while (!req.ready);
        sent++;
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        while (sb.checked < sent)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
    endtask

    task automatic random_item();
        int tot;
        int sel;
        int page;
        int count;
        tot   = sb.pages_now();
        sel   = $urandom_range(0, 99);
        page  = (tot > 0 && $urandom_range(0, 9) != 0) ? $urandom_range(0, tot - 1)
                                                       : $urandom_range(0, 65535);
        count = $urandom_range(1, tot / 4 + 2);
        if ($urandom_range(0, 40) == 0)
        begin
            count = $urandom_range(0, 65536);
        end
        if (sel < 25)
        begin
            send(bpa_pkg::CMD_ALLOC, $urandom_range(0, 65535), $urandom_range(0, 65536),
                 2'($urandom_range(0, 3)));
        end
        else if (sel < 38)
        begin
            send(bpa_pkg::CMD_CONTIG, page, ($urandom_range(0, 3) == 0) ? count
                                                                       : $urandom_range(0, 6),
                 2'($urandom_range(0, 3)));
        end
        else if (sel < 52)
        begin
            send(bpa_pkg::CMD_ZONE, page, count, 2'($urandom_range(0, 3)));
        end
        else if (sel < 74)
        begin
            send(bpa_pkg::CMD_FREE, page, count, 2'($urandom_range(0, 3)));
        end
        else if (sel < 83)
        begin
            send(bpa_pkg::CMD_RESERVE, page, count, 2'($urandom_range(0, 3)));
        end
        else if (sel < 97)
        begin
            send(bpa_pkg::CMD_RELEASE, page, count, 2'($urandom_range(0, 3)));
        end
        else
        begin
            send(($urandom_range(0, 1) == 0) ? CMD_UNDEF_LO : CMD_UNDEF_HI, page, count,
                 2'($urandom_range(0, 3)));
        end
    endtask

    task automatic run_phase(int total, int low, int dma, int normal, int n, bit idle,
                             bit stall);
        reg_write(bpa_pkg::REG_TOTAL, bpa_pkg::CNT_W'(total));
        reg_write(bpa_pkg::REG_LOW, bpa_pkg::CNT_W'(low));
        reg_write(bpa_pkg::REG_DMA, bpa_pkg::CNT_W'(dma));
        reg_write(bpa_pkg::REG_NORMAL, bpa_pkg::CNT_W'(normal));
        idle_on = idle;
        @(posedge clk);
        send(bpa_pkg::CMD_RELEASE, 0, total / 2 + 1, bpa_pkg::ZSEL_ANY);
        if (stall)
        begin
            hold_req = 1'b1;
        end
        for (int i = 0; i < n; i++)
        begin
            random_item();
        end
        drain();
        n_phases++;
    endtask

    initial
    begin
        sb        = new();
        sent      = 0;
        n_phases  = 0;
        rst_n     = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        req.valid = 1'b0;
        req.cmd   = '0;
        req.page  = '0;
        req.count = '0;
        req.zone  = '0;
        idle_on   = 1'b1;
        hold_req  = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send(bpa_pkg::CMD_ALLOC, 0, 0, bpa_pkg::ZSEL_LOW);
        send(bpa_pkg::CMD_CONTIG, 65535, 65536, bpa_pkg::ZSEL_ANY);
        send(bpa_pkg::CMD_RELEASE, 100, 64, bpa_pkg::ZSEL_DMA);
        send(bpa_pkg::CMD_ALLOC, 32768, 0, bpa_pkg::ZSEL_ANY);
        send(bpa_pkg::CMD_ALLOC, 0, 0, bpa_pkg::ZSEL_ANY);
        send(bpa_pkg::CMD_CONTIG, 0, 0, bpa_pkg::ZSEL_ANY);
        send(bpa_pkg::CMD_CONTIG, 0, 1, bpa_pkg::ZSEL_ANY);
        send(bpa_pkg::CMD_CONTIG, 0, 5, bpa_pkg::ZSEL_ANY);
        send(bpa_pkg::CMD_CONTIG, 0, 65536, bpa_pkg::ZSEL_ANY);
        send(bpa_pkg::CMD_FREE, 0, 0, bpa_pkg::ZSEL_ANY);
        send(bpa_pkg::CMD_FREE, 65535, 0, bpa_pkg::ZSEL_ANY);
        send(bpa_pkg::CMD_FREE, 100, 0, bpa_pkg::ZSEL_ANY);
        send(bpa_pkg::CMD_FREE, 100, 0, bpa_pkg::ZSEL_ANY);
        send(bpa_pkg::CMD_ZONE, 0, 0, bpa_pkg::ZSEL_LOW);
        send(bpa_pkg::CMD_ZONE, 0, 0, bpa_pkg::ZSEL_DMA);
        send(bpa_pkg::CMD_ZONE, 0, 0, bpa_pkg::ZSEL_NORMAL);
        send(bpa_pkg::CMD_ZONE, 0, 0, bpa_pkg::ZSEL_ANY);
        send(CMD_UNDEF_LO, 0, 0, bpa_pkg::ZSEL_ANY);
        send(CMD_UNDEF_HI, 65535, 131071, bpa_pkg::ZSEL_ANY);
        send(bpa_pkg::CMD_RESERVE, 90, 20, bpa_pkg::ZSEL_ANY);
        send(bpa_pkg::CMD_RELEASE, 65000, 65536, bpa_pkg::ZSEL_ANY);
        send(bpa_pkg::CMD_RELEASE, 0, 65536, bpa_pkg::ZSEL_ANY);
        send(bpa_pkg::CMD_RESERVE, 0, 65536, bpa_pkg::ZSEL_ANY);
        send(bpa_pkg::CMD_ALLOC, 0, 0, bpa_pkg::ZSEL_ANY);
        drain();

        run_phase(512, 0, 100, 65536, 170, 1'b1, 1'b0);
        run_phase(128, 128, 64, 1, 170, 1'b0, 1'b1);
        run_phase(0, 0, 0, 0, 20, 1'b1, 1'b0);
        run_phase(1000, 300, 700, 65536, 190, 1'b1, 1'b0);
        run_phase(4096, 256, 4096, 2000, 160, 1'b1, 1'b0);
        run_phase(200, 65536, 0, 150, 190, 1'b0, 1'b0);
        run_phase(65536, 256, 4096, 65536, 40, 1'b1, 1'b0);
        run_phase(300, 17, 299, 300, 190, 1'b1, 1'b0);
        run_phase(777, 1, 2, 3, 200, 1'b1, 1'b0);

        $display("%0d requests over %0d register settings, %0d response words checked",
                 sent, n_phases, sb.checked);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("%0d mismatches, %0d words never arrived", sb.mismatches,
                     sb.pending.size());
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+sv
sv/bpa_pkg.sv
sv/bpa_ifs.sv
sv/bpa_ram.sv
sv/bpa_ctl.sv
sv/bpa_dp.sv
sv/bitmap_page_allocator_unit.sv
sv/bpa_checker.sv
bench/bpa_alloc_scoreboard.sv
bench/testbench.sv
